// ----- hw/rtl/aqd_pkg.sv -----
// Shared types and codes for the array queue / deque block.
package aqd_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;
    localparam int MODE_W = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INS_REAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_REAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DISPLAY   = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_UNSUPP   = 2'd3;

    // Queue modes.
    localparam logic [MODE_W-1:0] MODE_LINEAR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CIRCULAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEQUE    = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] data_in;
    } aqd_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data_out;
        logic                     last;
    } aqd_rsp_t;

    // Result tag carried alongside a memory read.
    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic              last;
        logic              use_rd;
    } aqd_tag_t;

    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } aqd_state_t;

endpackage

// ----- hw/rtl/aqd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module aqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/aqd_obuf.sv -----
// Two-entry result buffer that decouples the queue logic from the result receiver.
module aqd_obuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  aqd_pkg::aqd_rsp_t push_data,
    output logic             valid,
    input  logic             ready,
    output aqd_pkg::aqd_rsp_t data,
    output logic [1:0]       count
);
    import aqd_pkg::*;

    aqd_rsp_t   ent_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign valid = (cnt_reg != 2'd0);
    assign data  = ent_reg[rd_ptr_reg];
    assign count = cnt_reg;
    assign pop   = valid && ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/array_queue_linear_circular_deque.sv -----
// Top level of the array-based queue with linear, circular and double-ended modes.
//
// Requests arrive on the req channel (valid/ready); a transfer happens at a
// rising edge where req_valid and req_ready are both high. Results leave on
// the rsp channel under the same rule. The mode register is written through
// cfg_we/cfg_wdata with no wait; any write empties the queue, and it should
// only be written while no request is in flight.
// Inserts, deletes and unsupported requests produce one result each, which
// is registered in the result stage and then in the result buffer before it
// appears on rsp. Such requests can be taken one per cycle while the buffer
// has room. A display of N elements produces N results and holds off new
// requests until its last element is read; each element is fetched through
// the single read port of the slot memory, one read per cycle when not stalled.
// Results pass through a two-entry buffer, so a new request is taken while
// an earlier result still waits. When the receiver stalls, reads and new
// requests are held back by a credit check on that buffer; nothing is lost.
// After reset the queue is empty, both indices are zero and the mode is
// linear. The slot memory needs no clearing, since only written slots are
// ever read. The double-ended mode keeps its contents in a ring, so an
// insert at either end is a single write and never a shift of the contents.
module array_queue_linear_circular_deque #(
    parameter int DEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  aqd_pkg::aqd_req_t              req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output aqd_pkg::aqd_rsp_t              rsp,
    input  logic                           cfg_we,
    input  logic [aqd_pkg::MODE_W-1:0]     cfg_wdata
);
    import aqd_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    // Architectural queue state.
    logic [MODE_W-1:0] mode_reg;
    logic [IW-1:0]     head_reg;
    logic [IW-1:0]     head_next;
    logic [IW-1:0]     tail_reg;
    logic [IW-1:0]     tail_next;
    logic              empty_reg;
    logic              empty_next;

    // Display walker and control.
    aqd_state_t        state_reg;
    aqd_state_t        state_next;
    logic [IW-1:0]     ptr_reg;
    logic [IW-1:0]     ptr_next;
    logic              disp_more;
    logic              disp_done;

    // Memory access for this cycle and the tag that follows the read.
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    aqd_tag_t          tag_next;
    aqd_tag_t          stage_reg;

    // Result buffer interface.
    aqd_rsp_t          push_data;
    logic [1:0]        obuf_cnt;
    logic              can_issue;
    logic [2:0]        fill;
    logic              accept;

    // Decode helpers.
    logic              mode_ok;
    logic              is_deque;
    logic              full;
    logic [IW-1:0]     head_inc;
    logic [IW-1:0]     head_dec;
    logic [IW-1:0]     tail_inc;
    logic [IW-1:0]     tail_dec;
    logic [IW-1:0]     ptr_inc;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign ptr_inc  = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;

    assign mode_ok  = (mode_reg == MODE_LINEAR) || (mode_reg == MODE_CIRCULAR) ||
                      (mode_reg == MODE_DEQUE);
    assign is_deque = (mode_reg == MODE_DEQUE);

    // The linear queue is full once the tail sits in the last slot; the ring
    // modes are full only when every slot holds an element.
    assign full = !empty_reg && ((mode_reg == MODE_LINEAR) ? (tail_reg == LAST_IDX)
                                                           : (head_reg == tail_inc));

    // Credit check: a result issued now passes the result stage before it lands
    // in the buffer, so the buffer must have room for it after the one already in
    // flight and any transfer happening this cycle.
    assign fill      = 3'(obuf_cnt) + 3'(stage_reg.valid);
    assign can_issue = (fill <= 3'd1 + 3'(rsp_valid && rsp_ready));

    assign req_ready = (state_reg == ST_IDLE) && can_issue;
    assign accept    = req_valid && req_ready;

    // Next-state logic for the display walker.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && disp_more)
                begin
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (disp_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Request decode, index updates and memory accesses.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        ptr_next   = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_inc;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        tag_next   = '0;
        disp_more  = 1'b0;
        disp_done  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tag_next.valid  = 1'b1;
                    tag_next.last   = 1'b1;
                    tag_next.status = STAT_UNSUPP;
                    case (req.req_type)
                        REQ_INS_REAR, REQ_INS_FRONT:
                        begin
                            if (mode_ok && (req.req_type == REQ_INS_REAR || is_deque))
                            begin
                                if (full)
                                begin
                                    tag_next.status = STAT_OVERFLOW;
                                end
                                else
                                begin
                                    tag_next.status = STAT_OK;
                                    wr_en           = 1'b1;
                                    if (empty_reg)
                                    begin
                                        head_next  = '0;
                                        tail_next  = '0;
                                        empty_next = 1'b0;
                                        wr_addr    = '0;
                                    end
                                    else if (req.req_type == REQ_INS_REAR)
                                    begin
                                        tail_next = tail_inc;
                                        wr_addr   = tail_inc;
                                    end
                                    else
                                    begin
                                        head_next = head_dec;
                                        wr_addr   = head_dec;
                                    end
                                end
                            end
                        end
                        REQ_DEL_FRONT, REQ_DEL_REAR:
                        begin
                            if (mode_ok && (req.req_type == REQ_DEL_FRONT || is_deque))
                            begin
                                if (empty_reg)
                                begin
                                    tag_next.status = STAT_EMPTY;
                                end
                                else
                                begin
                                    tag_next.status = STAT_OK;
                                    tag_next.use_rd = 1'b1;
                                    rd_en           = 1'b1;
                                    rd_addr = (req.req_type == REQ_DEL_FRONT) ? head_reg
                                                                              : tail_reg;
                                    if (head_reg == tail_reg)
                                    begin
                                        head_next  = '0;
                                        tail_next  = '0;
                                        empty_next = 1'b1;
                                    end
                                    else if (req.req_type == REQ_DEL_FRONT)
                                    begin
                                        head_next = head_inc;
                                    end
                                    else
                                    begin
                                        tail_next = tail_dec;
                                    end
                                end
                            end
                        end
                        REQ_DISPLAY:
                        begin
                            if (mode_ok)
                            begin
                                if (empty_reg)
                                begin
                                    tag_next.status = STAT_EMPTY;
                                end
                                else
                                begin
                                    tag_next.status = STAT_OK;
                                    tag_next.use_rd = 1'b1;
                                    tag_next.last   = (head_reg == tail_reg);
                                    rd_en           = 1'b1;
                                    rd_addr         = head_reg;
                                    disp_more       = (head_reg != tail_reg);
                                    ptr_next        = head_inc;
                                end
                            end
                        end
                        default:
                        begin
                            tag_next.status = STAT_UNSUPP;
                        end
                    endcase
                end
            end
            ST_DISP:
            begin
                if (can_issue)
                begin
                    tag_next.valid  = 1'b1;
                    tag_next.status = STAT_OK;
                    tag_next.use_rd = 1'b1;
                    tag_next.last   = (ptr_reg == tail_reg);
                    rd_en           = 1'b1;
                    rd_addr         = ptr_reg;
                    ptr_next        = ptr_inc;
                    disp_done       = (ptr_reg == tail_reg);
                end
            end
            default:
            begin
                tag_next = '0;
            end
        endcase
    end

    // A mode write empties the queue; it takes priority over request updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LINEAR;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            stage_reg <= tag_next;
            if (cfg_we)
            begin
                mode_reg  <= cfg_wdata;
                head_reg  <= '0;
                tail_reg  <= '0;
                empty_reg <= 1'b1;
            end
            else
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
            end
        end
    end

    // Writes happen only on insert cycles and reads only on delete or display
    // cycles, so one entry is never read and written in the same cycle.
    aqd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (req.data_in),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        push_data.status   = stage_reg.status;
        push_data.last     = stage_reg.last;
        push_data.data_out = stage_reg.use_rd ? rd_data : '0;
    end

    aqd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stage_reg.valid),
        .push_data (push_data),
        .valid     (rsp_valid),
        .ready     (rsp_ready),
        .data      (rsp),
        .count     (obuf_cnt)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg.valid |-> (obuf_cnt != 2'd2))
        else $error("result pushed into a full buffer");

    a_empty_indices: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty queue with nonzero indices");

    a_no_req_in_disp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISP) |-> !req_ready)
        else $error("request taken during display");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("slot memory read and written in one cycle");

    a_read_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> stage_reg.valid && stage_reg.use_rd)
        else $error("memory read without a result tag");
`endif

endmodule
